>>> rtl/lfe_pkg.sv
// lfe_pkg: shared types and codes for the led linear fade engine
// request and result structs, op/kind/component/config codes, sequencer and adjust states
// no dependencies
`timescale 1ns / 1ps

package lfe_pkg;

    localparam logic [2:0] OP_STAGE_COLOR  = 3'd0;
    localparam logic [2:0] OP_STAGE_BRIGHT = 3'd1;
    localparam logic [2:0] OP_START_COLOR  = 3'd2;
    localparam logic [2:0] OP_START_BRIGHT = 3'd3;
    localparam logic [2:0] OP_TICK         = 3'd4;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [1:0] COMP_RED    = 2'd0;
    localparam logic [1:0] COMP_GREEN  = 2'd1;
    localparam logic [1:0] COMP_BLUE   = 2'd2;
    localparam logic [1:0] COMP_BRIGHT = 2'd3;

    localparam logic CFG_COLOR_MAX  = 1'b0;
    localparam logic CFG_BRIGHT_MAX = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  module_req;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  bright_value;
        logic [15:0] fade_time;
    } req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] out_module;
        logic [1:0] component;
        logic [7:0] level;
        logic       fade_done;
        logic       all_finished;
        logic       last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STAGE,
        ST_NDIV,
        ST_SRD,
        ST_SCMP,
        ST_SDIV,
        ST_SWR,
        ST_TRD,
        ST_TEX1,
        ST_TEX2,
        ST_TEX3,
        ST_TEND,
        ST_ACK
    } state_t;

    typedef enum logic [2:0] {
        ADJ_HOLD,
        ADJ_SNAP,
        ADJ_MOVE,
        ADJ_ACC_WAIT,
        ADJ_ACC_FIRE
    } adj_t;

endpackage

>>> rtl/led_linear_fade_engine.sv
// led_linear_fade_engine: linear fade sequencer over per-channel level memories
// one shared restoring divider computes fade steps; uses lfe_pkg
// stage writes the staged levels, start computes a step for each channel whose target changed,
// tick updates each pending channel; every result is registered, and busy stays high until
// the last result
// one request at a time, results are one-cycle strobes; reset clears levels, steps, flags
`timescale 1ns / 1ps

module led_linear_fade_engine #(
    parameter int MODULES            = 8,
    parameter int REFRESH_PERIOD_MS  = 2,
    parameter int STEP_FRACTION_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lfe_pkg::req_t req,
    output logic          res_valid,
    output lfe_pkg::res_t res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [7:0]    cfg_data
);

    localparam int NCH   = MODULES * 4;
    localparam int MW    = (MODULES > 1) ? $clog2(MODULES) : 1;
    localparam int CW    = MW + 2;
    localparam int F     = STEP_FRACTION_BITS;
    localparam int SW    = F + 9;
    localparam int DW    = SW;
    localparam int CNTW  = $clog2(DW + 1);
    localparam int REC_W = 16 + 2 * SW;
    localparam logic signed [SW-1:0] ONE_FX  = SW'(1) << F;
    localparam logic signed [SW-1:0] NONE_FX = -(SW'(1) << F);
    localparam logic [SW-1:0]        HALF_FX = SW'(1) << (F - 1);
    // reciprocal of the refresh period, exact for every 16-bit duration
    localparam int          NSH  = 16 + $clog2(REFRESH_PERIOD_MS);
    localparam logic [33:0] NREC = 34'(((64'd1 << NSH) + 64'(REFRESH_PERIOD_MS) - 64'd1)
                                       / 64'(REFRESH_PERIOD_MS));

    // per-channel memories
    logic [REC_W-1:0] ch_mem  [NCH];
    logic [7:0]       stg_mem [NCH];
    logic [REC_W-1:0] ch_rd_reg;
    logic [7:0]       stg_rd_reg;
    logic             ch_rdv_reg, stg_rdv_reg;
    logic [NCH-1:0]   ch_vld_reg, stg_vld_reg;

    logic             ch_we, stg_we;
    logic [REC_W-1:0] ch_wd;
    logic [7:0]       stg_wd;

    lfe_pkg::state_t state_reg, state_next;
    lfe_pkg::adj_t   adj_reg, adj_next;
    lfe_pkg::req_t   cmd_reg, cmd_next;
    lfe_pkg::res_t   res_reg, res_next;
    logic            res_valid_reg, res_valid_next;
    logic [MW-1:0]   m_reg, m_next;
    logic [1:0]      c_reg, c_next;
    logic            pend_reg, pend_next;
    logic            cpend_reg, cpend_next;
    logic            bpend_reg, bpend_next;
    logic [15:0]     n_reg, n_next;
    logic [15:0]     div_rem_reg, div_rem_next;
    logic [DW-1:0]   div_quo_reg, div_quo_next;
    logic [15:0]     div_den_reg, div_den_next;
    logic [CNTW-1:0] div_cnt_reg, div_cnt_next;
    logic            neg_reg, neg_next;
    logic [SW-1:0]   acc_sum_reg, acc_sum_next;
    logic [9:0]      delta_reg, delta_next;
    logic [NCH-1:0]  eq_reg, eq_next;
    logic [2*MODULES-1:0] ong_reg, ong_next;
    logic [15:0]     dur_reg [2*MODULES];
    logic            dur_we;
    logic [7:0]      color_max_reg, bright_max_reg;

    // combinational helpers
    logic [CW-1:0]   idx;
    logic [MW:0]     dk;
    logic [REC_W-1:0] rec;
    logic [7:0]      r_cur, r_tgt, stg_q, absd, nvc, new_cur, clamp_v;
    logic [SW-1:0]   r_step, r_acc, sel_v, abs_v, new_acc, rsum;
    logic [SW-F-1:0] rmag;
    logic signed [10:0] nv;
    logic [16:0]     trial;
    logic            ge;
    logic [15:0]     rem_n;
    logic [DW-1:0]   quo_n;
    logic            is_tick, kb_start, kb, last_c, last_m, changed, done, new_eq, alleq;
    logic            cdone, bdone, step_pos, step_neg;
    logic [1:0]      first_c;
    logic [2:0]      ceq;

    assign busy      = (state_reg != lfe_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign idx = {m_reg, c_reg};
    assign kb  = (c_reg == lfe_pkg::COMP_BRIGHT);
    assign dk  = {m_reg, kb};

    always_ff @(posedge clk)
    begin
        ch_rd_reg  <= ch_mem[idx];
        stg_rd_reg <= stg_mem[idx];
        if (ch_we)
        begin
            ch_mem[idx] <= ch_wd;
        end
        if (stg_we)
        begin
            stg_mem[idx] <= stg_wd;
        end
        if (dur_we)
        begin
            dur_reg[{m_reg, cmd_reg.op == lfe_pkg::OP_STAGE_BRIGHT}] <= cmd_reg.fade_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_vld_reg  <= '0;
            stg_vld_reg <= '0;
            ch_rdv_reg  <= 1'b0;
            stg_rdv_reg <= 1'b0;
        end
        else
        begin
            ch_rdv_reg  <= ch_vld_reg[idx];
            stg_rdv_reg <= stg_vld_reg[idx];
            if (ch_we)
            begin
                ch_vld_reg[idx] <= 1'b1;
            end
            if (stg_we)
            begin
                stg_vld_reg[idx] <= 1'b1;
            end
        end
    end

    // a never-written duration entry reads as zero
    logic [2*MODULES-1:0] dur_vld_reg;
    logic [15:0]          dur_q;
    logic [33:0]          n_prod;
    logic [15:0]          n_q;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_vld_reg <= '0;
        end
        else if (dur_we)
        begin
            dur_vld_reg[{m_reg, cmd_reg.op == lfe_pkg::OP_STAGE_BRIGHT}] <= 1'b1;
        end
    end
    assign dur_q = dur_vld_reg[{m_reg, kb_start}] ? dur_reg[{m_reg, kb_start}] : 16'd0;

    // n = duration / refresh period by reciprocal multiply
    assign n_prod = 34'(dur_q) * NREC;
    assign n_q    = 16'(n_prod >> NSH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_max_reg  <= 8'd255;
            bright_max_reg <= 8'd255;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lfe_pkg::CFG_COLOR_MAX:  color_max_reg  <= cfg_data;
                lfe_pkg::CFG_BRIGHT_MAX: bright_max_reg <= cfg_data;
                default:                 color_max_reg  <= color_max_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfe_pkg::ST_IDLE;
            adj_reg       <= lfe_pkg::ADJ_HOLD;
            res_valid_reg <= 1'b0;
            m_reg         <= '0;
            c_reg         <= '0;
            pend_reg      <= 1'b0;
            cpend_reg     <= 1'b0;
            bpend_reg     <= 1'b0;
            div_cnt_reg   <= '0;
            eq_reg        <= '1;
            ong_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            adj_reg       <= adj_next;
            res_valid_reg <= res_valid_next;
            m_reg         <= m_next;
            c_reg         <= c_next;
            pend_reg      <= pend_next;
            cpend_reg     <= cpend_next;
            bpend_reg     <= bpend_next;
            div_cnt_reg   <= div_cnt_next;
            eq_reg        <= eq_next;
            ong_reg       <= ong_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        res_reg     <= res_next;
        n_reg       <= n_next;
        div_rem_reg <= div_rem_next;
        div_quo_reg <= div_quo_next;
        div_den_reg <= div_den_next;
        neg_reg     <= neg_next;
        acc_sum_reg <= acc_sum_next;
        delta_reg   <= delta_next;
    end

    // datapath decode
    assign rec      = ch_rdv_reg ? ch_rd_reg : '0;
    assign r_cur    = rec[REC_W-1 -: 8];
    assign r_tgt    = rec[REC_W-9 -: 8];
    assign r_step   = rec[2*SW-1 -: SW];
    assign r_acc    = rec[SW-1:0];
    assign stg_q    = stg_rdv_reg ? stg_rd_reg : 8'd0;
    assign step_neg = r_step[SW-1];
    assign step_pos = !r_step[SW-1] && (r_step != '0);

    // shared restoring divider step
    assign trial = {div_rem_reg, div_quo_reg[DW-1]};
    assign ge    = (trial >= {1'b0, div_den_reg});
    assign rem_n = ge ? 16'(trial - {1'b0, div_den_reg}) : trial[15:0];
    assign quo_n = {div_quo_reg[DW-2:0], ge};

    assign is_tick  = (cmd_reg.op == lfe_pkg::OP_TICK);
    assign kb_start = (cmd_reg.op == lfe_pkg::OP_START_BRIGHT);
    assign first_c  = is_tick ? (cpend_reg ? lfe_pkg::COMP_RED : lfe_pkg::COMP_BRIGHT)
                              : (kb_start ? lfe_pkg::COMP_BRIGHT : lfe_pkg::COMP_RED);
    assign last_c   = is_tick ? (c_reg == lfe_pkg::COMP_BRIGHT ||
                                 (c_reg == lfe_pkg::COMP_BLUE && !bpend_reg))
                              : (c_reg == lfe_pkg::COMP_BLUE || c_reg == lfe_pkg::COMP_BRIGHT);
    assign last_m   = (m_reg == MW'(MODULES - 1));
    assign absd     = (stg_q < r_cur) ? 8'(r_cur - stg_q) : 8'(stg_q - r_cur);

    // rounding, half away from zero
    assign sel_v = (adj_reg == lfe_pkg::ADJ_MOVE) ? r_step : acc_sum_reg;
    assign abs_v = sel_v[SW-1] ? SW'(-sel_v) : sel_v;
    assign rsum  = SW'(abs_v + HALF_FX);
    assign rmag  = rsum[SW-1:F];

    // apply delta with saturation at target and level range
    assign nv = $signed({3'b000, r_cur}) + $signed({delta_reg[9], delta_reg});
    always_comb
    begin
        clamp_v = nv[7:0];
        if (step_pos && nv > $signed({3'b000, r_tgt}))
        begin
            clamp_v = r_tgt;
        end
        else if (step_neg && nv < $signed({3'b000, r_tgt}))
        begin
            clamp_v = r_tgt;
        end
        else if (nv < 11'sd0)
        begin
            clamp_v = 8'd0;
        end
        else if (nv > 11'sd255)
        begin
            clamp_v = 8'd255;
        end
    end
    assign nvc = clamp_v;

    always_comb
    begin
        new_cur = r_cur;
        new_acc = r_acc;
        changed = 1'b0;
        case (adj_reg)
            lfe_pkg::ADJ_SNAP:
            begin
                new_cur = r_tgt;
                changed = 1'b1;
            end
            lfe_pkg::ADJ_MOVE:
            begin
                new_cur = nvc;
                changed = (nvc != r_cur);
            end
            lfe_pkg::ADJ_ACC_FIRE:
            begin
                new_cur = nvc;
                new_acc = '0;
                changed = (nvc != r_cur);
            end
            lfe_pkg::ADJ_ACC_WAIT:
            begin
                new_acc = acc_sum_reg;
            end
            default:
            begin
                new_cur = r_cur;
            end
        endcase
    end

    assign new_eq = (new_cur == r_tgt);
    always_comb
    begin
        ceq = {eq_reg[{m_reg, lfe_pkg::COMP_BLUE}], eq_reg[{m_reg, lfe_pkg::COMP_GREEN}],
               eq_reg[{m_reg, lfe_pkg::COMP_RED}]};
        if (!kb)
        begin
            ceq[c_reg] = new_eq;
        end
    end
    assign alleq = kb ? new_eq : (&ceq);
    assign done  = (changed || ong_reg[dk]) && alleq;

    always_comb
    begin
        cdone = 1'b1;
        bdone = 1'b1;
        for (int i = 0; i < MODULES; i++)
        begin
            if (!eq_reg[i*4] || !eq_reg[i*4+1] || !eq_reg[i*4+2] || ong_reg[i*2])
            begin
                cdone = 1'b0;
            end
            if (!eq_reg[i*4+3] || ong_reg[i*2+1])
            begin
                bdone = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        adj_next       = adj_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        m_next         = m_reg;
        c_next         = c_reg;
        pend_next      = pend_reg;
        cpend_next     = cpend_reg;
        bpend_next     = bpend_reg;
        n_next         = n_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;
        neg_next       = neg_reg;
        acc_sum_next   = acc_sum_reg;
        delta_next     = delta_reg;
        eq_next        = eq_reg;
        ong_next       = ong_reg;
        ch_we          = 1'b0;
        ch_wd          = {new_cur, r_tgt, r_step, new_acc};
        stg_we         = 1'b0;
        stg_wd         = 8'd0;
        dur_we         = 1'b0;

        unique case (state_reg)
            lfe_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = req;
                    m_next    = '0;
                    pend_next = 1'b0;
                    unique case (req.op)
                        lfe_pkg::OP_STAGE_COLOR, lfe_pkg::OP_STAGE_BRIGHT:
                        begin
                            m_next = MW'(req.module_req);
                            c_next = (req.op == lfe_pkg::OP_STAGE_COLOR) ?
                                     lfe_pkg::COMP_RED : lfe_pkg::COMP_BRIGHT;
                            state_next = (32'(req.module_req) < MODULES) ?
                                         lfe_pkg::ST_STAGE : lfe_pkg::ST_ACK;
                        end
                        lfe_pkg::OP_START_COLOR, lfe_pkg::OP_START_BRIGHT:
                        begin
                            state_next = lfe_pkg::ST_NDIV;
                        end
                        lfe_pkg::OP_TICK:
                        begin
                            c_next     = cpend_reg ? lfe_pkg::COMP_RED : lfe_pkg::COMP_BRIGHT;
                            state_next = (cpend_reg || bpend_reg) ?
                                         lfe_pkg::ST_TRD : lfe_pkg::ST_TEND;
                        end
                        default:
                        begin
                            state_next = lfe_pkg::ST_ACK;
                        end
                    endcase
                end
            end

            lfe_pkg::ST_STAGE:
            begin
                stg_we = 1'b1;
                unique case (c_reg)
                    lfe_pkg::COMP_RED:
                        stg_wd = (cmd_reg.red <= color_max_reg) ? cmd_reg.red : color_max_reg;
                    lfe_pkg::COMP_GREEN:
                        stg_wd = (cmd_reg.green <= color_max_reg) ? cmd_reg.green
                                                                  : color_max_reg;
                    lfe_pkg::COMP_BLUE:
                        stg_wd = (cmd_reg.blue <= color_max_reg) ? cmd_reg.blue : color_max_reg;
                    default:
                        stg_wd = (cmd_reg.bright_value <= bright_max_reg) ?
                                 cmd_reg.bright_value : bright_max_reg;
                endcase
                if (c_reg == lfe_pkg::COMP_RED || c_reg == lfe_pkg::COMP_BRIGHT)
                begin
                    dur_we = 1'b1;
                    ong_next[{m_reg, c_reg == lfe_pkg::COMP_BRIGHT}] = 1'b1;
                end
                if (c_reg == lfe_pkg::COMP_BLUE || c_reg == lfe_pkg::COMP_BRIGHT)
                begin
                    state_next = lfe_pkg::ST_ACK;
                end
                else
                begin
                    c_next = 2'(c_reg + 2'd1);
                end
            end

            lfe_pkg::ST_NDIV:
            begin
                // per-module tick count and ongoing check
                n_next = n_q;
                if (ong_reg[{m_reg, kb_start}])
                begin
                    pend_next = 1'b1;
                end
                c_next     = first_c;
                state_next = lfe_pkg::ST_SRD;
            end

            lfe_pkg::ST_SRD:
            begin
                state_next = lfe_pkg::ST_SCMP;
            end

            lfe_pkg::ST_SCMP:
            begin
                if (stg_q != r_tgt)
                begin
                    pend_next    = 1'b1;
                    neg_next     = (stg_q < r_cur);
                    div_rem_next = '0;
                    div_den_next = n_reg;
                    div_cnt_next = '0;
                    if (n_reg == 16'd0)
                    begin
                        div_quo_next = DW'({absd, {F{1'b0}}});
                        state_next   = lfe_pkg::ST_SWR;
                    end
                    else
                    begin
                        div_quo_next = DW'(DW'({absd, {F{1'b0}}}) + DW'(n_reg[15:1]));
                        state_next   = lfe_pkg::ST_SDIV;
                    end
                end
                else
                begin
                    state_next = lfe_pkg::ST_SWR;
                    div_cnt_next = CNTW'(1);
                end
            end

            lfe_pkg::ST_SDIV:
            begin
                div_rem_next = rem_n;
                div_quo_next = quo_n;
                div_cnt_next = CNTW'(div_cnt_reg + 1'b1);
                if (div_cnt_reg == CNTW'(DW - 1))
                begin
                    div_cnt_next = '0;
                    state_next   = lfe_pkg::ST_SWR;
                end
            end

            lfe_pkg::ST_SWR:
            begin
                // unchanged target leaves step and accumulator alone
                if (div_cnt_reg == '0)
                begin
                    ch_we        = 1'b1;
                    ch_wd        = {r_cur, stg_q,
                                    neg_reg ? SW'(-div_quo_reg) : SW'(div_quo_reg), SW'(0)};
                    eq_next[idx] = (r_cur == stg_q);
                end
                div_cnt_next = '0;
                if (!last_c)
                begin
                    c_next     = 2'(c_reg + 2'd1);
                    state_next = lfe_pkg::ST_SRD;
                end
                else if (!last_m)
                begin
                    m_next     = MW'(m_reg + 1'b1);
                    state_next = lfe_pkg::ST_NDIV;
                end
                else
                begin
                    if (kb_start)
                    begin
                        bpend_next = pend_reg;
                    end
                    else
                    begin
                        cpend_next = pend_reg;
                    end
                    state_next = lfe_pkg::ST_ACK;
                end
            end

            lfe_pkg::ST_TRD:
            begin
                state_next = lfe_pkg::ST_TEX1;
            end

            lfe_pkg::ST_TEX1:
            begin
                acc_sum_next = SW'(r_acc + r_step);
                if (r_cur == r_tgt)
                begin
                    adj_next = lfe_pkg::ADJ_HOLD;
                end
                else if ((step_pos && r_cur >= r_tgt) || (step_neg && r_cur <= r_tgt))
                begin
                    adj_next = lfe_pkg::ADJ_SNAP;
                end
                else if ($signed(r_step) >= ONE_FX || $signed(r_step) <= NONE_FX)
                begin
                    adj_next = lfe_pkg::ADJ_MOVE;
                end
                else
                begin
                    adj_next = lfe_pkg::ADJ_ACC_WAIT;
                end
                state_next = lfe_pkg::ST_TEX2;
            end

            lfe_pkg::ST_TEX2:
            begin
                delta_next = sel_v[SW-1] ? 10'(-{1'b0, rmag}) : 10'({1'b0, rmag});
                if (adj_reg == lfe_pkg::ADJ_ACC_WAIT &&
                    ($signed(acc_sum_reg) >= ONE_FX || $signed(acc_sum_reg) <= NONE_FX))
                begin
                    adj_next = lfe_pkg::ADJ_ACC_FIRE;
                end
                state_next = lfe_pkg::ST_TEX3;
            end

            lfe_pkg::ST_TEX3:
            begin
                ch_we        = 1'b1;
                eq_next[idx] = new_eq;
                if (done)
                begin
                    ong_next[dk] = 1'b0;
                end
                if (changed || done)
                begin
                    res_valid_next        = 1'b1;
                    res_next.kind         = lfe_pkg::KIND_REPORT;
                    res_next.out_module   = 3'(m_reg);
                    res_next.component    = c_reg;
                    res_next.level        = new_cur;
                    res_next.fade_done    = done;
                    res_next.all_finished = 1'b0;
                    res_next.last         = 1'b0;
                end
                if (!last_c)
                begin
                    c_next     = 2'(c_reg + 2'd1);
                    state_next = lfe_pkg::ST_TRD;
                end
                else if (!last_m)
                begin
                    m_next     = MW'(m_reg + 1'b1);
                    c_next     = first_c;
                    state_next = lfe_pkg::ST_TRD;
                end
                else
                begin
                    state_next = lfe_pkg::ST_TEND;
                end
            end

            lfe_pkg::ST_TEND:
            begin
                cpend_next            = cpend_reg && !cdone;
                bpend_next            = bpend_reg && !bdone;
                res_valid_next        = 1'b1;
                res_next              = '0;
                res_next.kind         = lfe_pkg::KIND_END;
                res_next.all_finished = !(cpend_reg && !cdone) && !(bpend_reg && !bdone);
                res_next.last         = 1'b1;
                state_next            = lfe_pkg::ST_IDLE;
            end

            lfe_pkg::ST_ACK:
            begin
                res_valid_next = 1'b1;
                res_next       = '0;
                res_next.kind  = lfe_pkg::KIND_ACK;
                res_next.last  = 1'b1;
                state_next     = lfe_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = lfe_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |-> !busy)
        else $error("block still busy after final result");

    a_res_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(busy))
        else $error("result without a request in progress");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lfe_pkg::ST_SDIV |-> div_cnt_reg < CNTW'(DW))
        else $error("divider ran past its width");
`endif

endmodule
